// ===== rtl/ubd_pkg.sv =====
// Package for the UART baud divisor calculator: field widths, fixed-point
// constants and the request, response and sideband structs.
// No dependencies; every other file in rtl/ imports it.
package ubd_pkg;

  localparam int PCLK_W    = 27;
  localparam int BAUD_W    = 24;
  localparam int MANT_W    = 12;
  localparam int FRAC_W    = 4;
  localparam int WORD_W    = 16;

  localparam int MANTISSA_BITS_DEFAULT = 12;

  // Dividend is pclk * 25, divisor is baud * k with k = 2 or 4.
  localparam int NUM_W      = 32;
  localparam int DEN_W      = BAUD_W + 2;
  localparam int STEP_BITS  = 2;
  localparam int DIV_STAGES = NUM_W / STEP_BITS;

  // Quotient / 100 stays below 2**26 for any 32-bit quotient.
  localparam int MANT_RAW_W = 26;
  localparam int MANT_C_W   = MANT_RAW_W + 1;
  localparam int REM_W      = 7;
  localparam int VAL_W      = 11;
  localparam int FR_W       = 5;

  localparam logic [NUM_W-1:0] CLK_SCALE  = 32'd25;
  localparam logic [NUM_W-1:0] SCALE      = 32'd100;
  localparam logic [VAL_W-1:0] ROUND_HALF = 11'd50;

  // floor(x / 100) = (x * RECIP_100) >> 37 for every 32-bit x.
  localparam logic [NUM_W-1:0] RECIP_100   = 32'd1374389535;
  localparam int               RECIP_SHIFT = 37;
  // floor(v / 100) = (v * 1311) >> 17 for every v below 2048 with v % 100 <= 99.
  localparam logic [VAL_W-1:0] FRAC_RECIP  = 11'd1311;
  localparam int               FRAC_SHIFT  = 17;

  localparam logic [FR_W-1:0] N_OVER8  = 5'd8;
  localparam logic [FR_W-1:0] N_OVER16 = 5'd16;
  localparam logic [FRAC_W-1:0] FRAC_MAX_OVER8  = 4'd7;
  localparam logic [FRAC_W-1:0] FRAC_MAX_OVER16 = 4'd15;

  typedef struct packed {
    logic [PCLK_W-1:0] pclk_hz;
    logic [BAUD_W-1:0] baud_rate;
    logic              oversample_by_8;
  } ubd_req_t;

  typedef struct packed {
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] fraction;
    logic [WORD_W-1:0] divisor_word;
    logic              saturated;
  } ubd_rsp_t;

  // Control bits that travel alongside the divider data.
  typedef struct packed {
    logic baud_zero;
    logic over8;
  } ubd_side_t;

endpackage

// ===== rtl/ubd_divider.sv =====
// Pipelined restoring divider for the baud divisor calculator.
// Produces STEP_BITS quotient bits per register stage; depends on ubd_pkg.
module ubd_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [ubd_pkg::NUM_W-1:0] num,
  input  logic [ubd_pkg::DEN_W-1:0] den,
  input  ubd_pkg::ubd_side_t       side,
  output logic                     out_vld,
  output logic [ubd_pkg::NUM_W-1:0] quo,
  output ubd_pkg::ubd_side_t       out_side
);
  import ubd_pkg::*;

  logic [DEN_W-1:0] rem_w  [0:DIV_STAGES];
  logic [NUM_W-1:0] num_w  [0:DIV_STAGES];
  logic [DEN_W-1:0] den_w  [0:DIV_STAGES];
  ubd_side_t        side_w [0:DIV_STAGES];
  logic             vld_w  [0:DIV_STAGES];

  assign rem_w[0]  = '0;
  assign num_w[0]  = num;
  assign den_w[0]  = den;
  assign side_w[0] = side;
  assign vld_w[0]  = in_vld;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DEN_W-1:0] rem_r;
    logic [NUM_W-1:0] num_r;
    logic [DEN_W-1:0] den_r;
    ubd_side_t        side_r;
    logic             vld_r;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] num_next;
    logic [DEN_W:0]   trial;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
      rem_next = rem_w[s];
      num_next = num_w[s];
      trial    = '0;
      for (int b = 0; b < STEP_BITS; b++) begin
        trial    = {rem_next, num_next[NUM_W-1]};
        num_next = {num_next[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den_w[s]}) begin
          rem_next    = DEN_W'(trial - {1'b0, den_w[s]});
          num_next[0] = 1'b1;
        end else begin
          rem_next = trial[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_next;
        num_r  <= num_next;
        den_r  <= den_w[s];
        side_r <= side_w[s];
      end
    end

    assign rem_w[s+1]  = rem_r;
    assign num_w[s+1]  = num_r;
    assign den_w[s+1]  = den_r;
    assign side_w[s+1] = side_r;
    assign vld_w[s+1]  = vld_r;
  end

  assign out_vld  = vld_w[DIV_STAGES];
  assign quo      = num_w[DIV_STAGES];
  assign out_side = side_w[DIV_STAGES];

endmodule

// ===== rtl/uart_baud_divisor_calc.sv =====
// Top level of the UART fractional baud divisor calculator.
// Depends on ubd_pkg and ubd_divider.
//
// Usage: a request (clock in Hz, baud rate, oversampling mode) is offered on
// req with req_valid/req_ready; a transfer happens when both are high. The
// divisor appears on rsp with rsp_valid/rsp_ready, one response per request,
// in request order.
// Pipeline: 21 register stages from the request transfer to the response:
// one input stage, 16 divider stages (two quotient bits each) and four stages
// for the divide by 100, the fraction rounding and the carry and clamp.
// Throughput: one request per cycle while no response is stalled; the 16-stage
// restoring divider sets the depth of the pipe.
// A zero baud rate gives a saturated result.
// Reset clears every valid bit, so the pipe starts empty with rsp_valid low.
// While the receiver stalls a waiting response, the whole pipe holds and
// req_ready is low; nothing is dropped or repeated.
module uart_baud_divisor_calc #(
  parameter int MANTISSA_BITS = ubd_pkg::MANTISSA_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ubd_pkg::ubd_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ubd_pkg::ubd_rsp_t rsp
);
  import ubd_pkg::*;

  localparam logic [MANT_C_W-1:0] MantMax =
    MANT_C_W'((64'd1 << MANTISSA_BITS) - 64'd1);

  logic en;
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  // Input stage: scaled clock and divisor.
  logic             p_vld;
  logic [NUM_W-1:0] p_num;
  logic [DEN_W-1:0] p_den;
  ubd_side_t        p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num <= NUM_W'(req.pclk_hz) * CLK_SCALE;
      p_den <= req.oversample_by_8 ? {1'b0, req.baud_rate, 1'b0} : {req.baud_rate, 2'b00};
      p_side.baud_zero <= (req.baud_rate == '0);
      p_side.over8     <= req.oversample_by_8;
    end
  end

  logic             d_vld;
  logic [NUM_W-1:0] d_quo;
  ubd_side_t        d_side;

  ubd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (p_vld),
    .num      (p_num),
    .den      (p_den),
    .side     (p_side),
    .out_vld  (d_vld),
    .quo      (d_quo),
    .out_side (d_side)
  );

  // Stage M: integer part by reciprocal multiplication.
  logic [2*NUM_W-1:0]    m_prod;
  logic                  m_vld;
  logic [NUM_W-1:0]      m_quo;
  logic [MANT_RAW_W-1:0] m_mant;
  ubd_side_t             m_side;

  assign m_prod = {{NUM_W{1'b0}}, d_quo} * {{NUM_W{1'b0}}, RECIP_100};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_quo  <= d_quo;
      m_mant <= m_prod[RECIP_SHIFT +: MANT_RAW_W];
      m_side <= d_side;
    end
  end

  // Stage V: remainder of the divide by 100, scaled by N and biased for rounding.
  logic [NUM_W-1:0]      v_back;
  logic [REM_W-1:0]      v_rem;
  logic                  v_vld;
  logic [VAL_W-1:0]      v_val;
  logic [MANT_RAW_W-1:0] v_mant;
  ubd_side_t             v_side;

  assign v_back = NUM_W'(m_mant) * SCALE;
  assign v_rem  = REM_W'(m_quo - v_back);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_vld <= 1'b0;
    end else if (en) begin
      v_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_val  <= (m_side.over8 ? {1'b0, v_rem, 3'b000} : {v_rem, 4'b0000}) + ROUND_HALF;
      v_mant <= m_mant;
      v_side <= m_side;
    end
  end

  // Stage F: rounded fraction, which may still equal N.
  logic [2*VAL_W-1:0]    f_prod;
  logic                  f_vld;
  logic [FR_W-1:0]       f_frac;
  logic [MANT_RAW_W-1:0] f_mant;
  ubd_side_t             f_side;

  assign f_prod = (2*VAL_W)'(v_val) * (2*VAL_W)'(FRAC_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= v_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_frac <= f_prod[FRAC_SHIFT +: FR_W];
      f_mant <= v_mant;
      f_side <= v_side;
    end
  end

  // Output stage: carry a fraction of N into the mantissa, then clamp.
  logic [FR_W-1:0]     o_n;
  logic [FR_W-1:0]     o_frac;
  logic [MANT_C_W-1:0] o_mant;
  logic                o_sat;
  logic [FRAC_W-1:0]   o_frac_sel;
  logic [MANT_C_W-1:0] o_mant_sel;
  ubd_rsp_t            rsp_next;

  always_comb begin
    o_n = f_side.over8 ? N_OVER8 : N_OVER16;
    if (f_frac >= o_n) begin
      o_frac = f_frac - o_n;
      o_mant = {1'b0, f_mant} + MANT_C_W'(1);
    end else begin
      o_frac = f_frac;
      o_mant = {1'b0, f_mant};
    end
    o_sat = f_side.baud_zero || (o_mant > MantMax);
    if (o_sat) begin
      o_mant_sel = MantMax;
      o_frac_sel = f_side.over8 ? FRAC_MAX_OVER8 : FRAC_MAX_OVER16;
    end else begin
      o_mant_sel = o_mant;
      o_frac_sel = o_frac[FRAC_W-1:0];
    end
    rsp_next.mantissa     = o_mant_sel[MANT_W-1:0];
    rsp_next.fraction     = o_frac_sel;
    rsp_next.divisor_word = {o_mant_sel[MANT_W-1:0], o_frac_sel};
    rsp_next.saturated    = o_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

  // The reciprocal divide by 100 must leave a remainder below 100.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v_vld |-> v_val <= 11'd1634)
    else $error("scaled remainder out of range");

  // Rounding can reach N but never exceed it.
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    f_vld |-> f_frac <= N_OVER16)
    else $error("rounded fraction above N");

  // A zero baud rate reaching the last stage must come out saturated.
  a_zero_baud: assert property (@(posedge clk) disable iff (rst)
    en && f_vld && f_side.baud_zero |=> rsp_valid && rsp.saturated)
    else $error("zero baud rate not saturated");

  // A clamped result carries the largest fraction of its mode.
  a_sat_frac: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.saturated |->
      rsp.fraction == FRAC_MAX_OVER8 || rsp.fraction == FRAC_MAX_OVER16)
    else $error("saturated result with wrong fraction");

endmodule

// ===== dv/ubd_checker.sv =====
// Checker for the UART baud divisor calculator: predicts each divisor from the
// accepted request and compares it with the response stream in order.
// Depends on ubd_pkg for the request and response structs and field widths.
module ubd_checker #(
  parameter int MANTISSA_BITS = ubd_pkg::MANTISSA_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  ubd_pkg::ubd_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  ubd_pkg::ubd_rsp_t rsp,
  output int                fail_count,
  output int                outstanding,
  output int                checked,
  output int                saturated_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] CLOCK_SCALE = 64'd25;
  localparam logic [63:0] CENTI       = 64'd100;
  localparam logic [63:0] HALF_CENTI  = 64'd50;

  ubd_pkg::ubd_rsp_t divisor_queue[$];

  function automatic ubd_pkg::ubd_rsp_t divisor_of(input ubd_pkg::ubd_req_t r);
    logic [63:0] steps;
    logic [63:0] half_steps;
    logic [63:0] mant_limit;
    logic [63:0] centi_div;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] frac;
    logic [63:0] word;
    logic        clamped;
    ubd_pkg::ubd_rsp_t d;
    steps      = r.oversample_by_8 ? 64'd8 : 64'd16;
    half_steps = r.oversample_by_8 ? 64'd2 : 64'd4;
    mant_limit = (64'd1 << MANTISSA_BITS) - 64'd1;
    clamped    = 1'b0;
    if (r.baud_rate == '0) begin
      // A zero line rate means an unbounded divisor, so it clamps outright.
      mant    = mant_limit;
      frac    = steps - 64'd1;
      clamped = 1'b1;
    end else begin
      centi_div = (64'(r.pclk_hz) * CLOCK_SCALE) / (half_steps * 64'(r.baud_rate));
      mant      = centi_div / CENTI;
      rem       = centi_div - mant * CENTI;
      frac      = (rem * steps + HALF_CENTI) / CENTI;
      // A fraction that rounds up to a whole step carries into the mantissa;
      // the clamp is decided after the carry.
      if (frac >= steps) begin
        frac = frac - steps;
        mant = mant + 64'd1;
      end
      if (mant > mant_limit) begin
        mant    = mant_limit;
        frac    = steps - 64'd1;
        clamped = 1'b1;
      end
    end
    word           = (mant << 4) | {60'd0, frac[3:0]};
    d.mantissa     = mant[ubd_pkg::MANT_W-1:0];
    d.fraction     = frac[ubd_pkg::FRAC_W-1:0];
    d.divisor_word = word[ubd_pkg::WORD_W-1:0];
    d.saturated    = clamped;
    return d;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0d (0x%h), actual %0d (0x%h)",
               $time, field, want, want, got, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ubd_pkg::ubd_rsp_t want;
    if (!rst) begin
      // Retire the response before queueing the request of the same edge.
      if (rsp_valid && rsp_ready) begin
        if (divisor_queue.size() == 0) begin
          $display("%0t ns: unexpected response: expected none, actual 0x%h",
                   $time, rsp);
          fail_count++;
        end else begin
          want = divisor_queue.pop_front();
          compare_field("mantissa", 16'(want.mantissa), 16'(rsp.mantissa));
          compare_field("fraction", 16'(want.fraction), 16'(rsp.fraction));
          compare_field("divisor_word", want.divisor_word, rsp.divisor_word);
          compare_field("saturated", 16'(want.saturated), 16'(rsp.saturated));
          checked++;
          if (want.saturated) begin
            saturated_seen++;
          end
        end
      end
      if (req_valid && req_ready) begin
        divisor_queue.push_back(divisor_of(req));
      end
    end
    outstanding <= divisor_queue.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for uart_baud_divisor_calc: clock, reset, request stimulus and
// response back-pressure, with ubd_checker alongside to predict and compare.
// Depends on ubd_pkg, uart_baud_divisor_calc and ubd_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MANT_BITS    = ubd_pkg::MANTISSA_BITS_DEFAULT;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          CYCLE_LIMIT  = 60000;
  localparam logic [31:0] PCLK_MAX     = 32'h07FF_FFFF;
  localparam logic [31:0] BAUD_MAX     = 32'h00FF_FFFF;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  ubd_pkg::ubd_req_t req = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  ubd_pkg::ubd_rsp_t rsp;

  int fail_count;
  int outstanding;
  int checked;
  int saturated_seen;
  int cycle_count = 0;
  int directed_sent = 0;
  int random_sent = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  int unsigned std_baud [15] = '{300, 1200, 2400, 9600, 19200, 38400, 57600, 115200,
                                 230400, 460800, 921600, 2000000, 3000000, 4000000,
                                 12000000};

  uart_baud_divisor_calc #(.MANTISSA_BITS(MANT_BITS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  ubd_checker #(.MANTISSA_BITS(MANT_BITS)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .checked        (checked),
    .saturated_seen (saturated_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Response side: random stalls of rsp_ready while idling is enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 3);
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d divisors outstanding.",
             cycle_count, outstanding);
    $display("** uart_baud_divisor_calc: FAILED **");
    $finish;
  end

  function automatic ubd_pkg::ubd_req_t mk_req(input logic [31:0] pclk,
                                               input logic [31:0] baud,
                                               input logic over8);
    ubd_pkg::ubd_req_t r;
    r.pclk_hz         = pclk[ubd_pkg::PCLK_W-1:0];
    r.baud_rate       = baud[ubd_pkg::BAUD_W-1:0];
    r.oversample_by_8 = over8;
    return r;
  endfunction

  // Presents one request and returns at the edge where its transfer happens.
  task automatic send(input ubd_pkg::ubd_req_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
  endtask

  initial begin
    logic [31:0] pclk;
    logic [31:0] baud;
    logic [31:0] target;
    logic        over8;
    int          kind;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes, zero clock and zero line rate.
    send(mk_req(32'd0, 32'd1, 1'b0));
    send(mk_req(32'd0, 32'd0, 1'b1));
    send(mk_req(PCLK_MAX, 32'd0, 1'b1));
    send(mk_req(PCLK_MAX, 32'd1, 1'b0));
    send(mk_req(PCLK_MAX, BAUD_MAX, 1'b1));
    send(mk_req(32'd1, BAUD_MAX, 1'b0));
    send(mk_req(32'd1, 32'd1, 1'b1));
    send(mk_req(32'h0555_5555, 32'h00AA_AAAA, 1'b0));
    send(mk_req(32'h02AA_AAAA, 32'h0055_5555, 1'b1));
    // Everyday clock and line rate pairs in both modes.
    send(mk_req(32'd16_000_000, 32'd9600, 1'b0));
    send(mk_req(32'd84_000_000, 32'd115200, 1'b1));
    send(mk_req(32'd42_000_000, 32'd115200, 1'b0));
    send(mk_req(32'd100_000_000, 32'd12_000_000, 1'b1));
    // Fractions that round up to a whole step and carry into the mantissa.
    send(mk_req(32'd396, 32'd25, 1'b0));
    send(mk_req(32'd198, 32'd25, 1'b1));
    // Around the mantissa ceiling, including a carry that pushes it over.
    send(mk_req(32'd1638384, 32'd25, 1'b0));
    send(mk_req(32'd1638396, 32'd25, 1'b0));
    send(mk_req(32'd1638400, 32'd25, 1'b0));
    send(mk_req(32'd819198, 32'd25, 1'b1));
    send(mk_req(32'd819190, 32'd25, 1'b1));
    directed_sent = 20;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Idling pauses for a stretch in the middle and stops for the tail.
      idle_on = (i < 140) || (i >= 200 && i < 330);
      over8   = 1'($urandom_range(0, 1));
      kind    = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          pclk = $urandom_range(0, PCLK_MAX);
          baud = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(0, BAUD_MAX);
        end
        2: begin
          pclk = $urandom_range(0, PCLK_MAX);
          baud = $urandom_range(1, 4095);
        end
        9: begin
          pclk = $urandom_range(1_000_000, 100_000_000);
          baud = std_baud[$urandom_range(0, 14)];
        end
        default: begin
          // Aim at a chosen mantissa so the whole range, the ceiling included,
          // is reached with random fractions.
          pclk   = $urandom_range(1_000_000, 100_000_000);
          target = $urandom_range(1, 4200);
          baud   = pclk / ((over8 ? 32'd8 : 32'd16) * target) + $urandom_range(0, 1);
          if (baud == 0) begin
            baud = 32'd1;
          end
        end
      endcase
      send(mk_req(pclk, baud, over8));
      random_sent++;
    end
    req_valid <= 1'b0;
    idle_on = 1'b0;

    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (32) @(posedge clk);

    $display("Covered %0d requests (%0d directed, %0d random) in both oversampling modes.",
             directed_sent + random_sent, directed_sent, random_sent);
    $display("Checked %0d divisors, %0d of them clamped at the mantissa ceiling.",
             checked, saturated_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** uart_baud_divisor_calc: PASSED **");
    end else begin
      $display("** uart_baud_divisor_calc: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ubd_pkg.sv
rtl/ubd_divider.sv
rtl/uart_baud_divisor_calc.sv
dv/ubd_checker.sv
dv/tb_top.sv
